// ----- hw/rtl/uwbtwr_pkg.sv -----
// Shared types and constants for the two-way ranging initiator.
// Used by the response checker, the distance scaler and the top level.
package uwbtwr_pkg;

  localparam int TS_BITS     = 40;
  localparam int SEQ_W       = 8;
  localparam int BYTE_W      = 8;
  localparam int DIST_W      = 31;
  localparam int SCALE_W     = 20;
  localparam int SCALE_SHIFT = 17;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SCALE_W-1:0] SCALE_RST       = SCALE_W'(307479);
  localparam logic [BYTE_W-1:0]  MAGIC_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0]  MAGIC_SECOND_RST = 8'hAA;
  localparam logic [BYTE_W-1:0]  MSG_TYPE_RESP    = 8'h02;
  localparam logic [BYTE_W-1:0]  MIN_FRAME_LEN    = 8'd9;

  typedef enum logic [1:0] {
    MODE_START     = 2'd0,
    MODE_POLL_SENT = 2'd1,
    MODE_RESP      = 2'd2,
    MODE_TIMEOUT   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TIMEOUT    = 3'd1,
    ST_BAD_FMT    = 3'd2,
    ST_NEG_FLIGHT = 3'd3,
    ST_IDLE_ACK   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    SEND_NONE   = 3'd0,
    SEND_POLL   = 3'd1,
    SEND_RESULT = 3'd4
  } send_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE        = 2'd0,
    CFG_MAGIC_FIRST  = 2'd1,
    CFG_MAGIC_SECOND = 2'd2
  } cfg_idx_t;

  // Response check result handed from the checker to the pipeline.
  typedef struct packed {
    logic               fmt_ok;
    logic               too_short;
    logic [TS_BITS-1:0] ticks;
  } resp_chk_t;

endpackage

// ----- hw/rtl/uwbtwr_resp_chk.sv -----
// Response frame check and flight-time extraction.
// Depends on uwbtwr_pkg for widths and the resp_chk_t struct.
module uwbtwr_resp_chk import uwbtwr_pkg::*; (
  input  logic [BYTE_W-1:0]  hdr_byte0,
  input  logic [BYTE_W-1:0]  hdr_byte1,
  input  logic [BYTE_W-1:0]  msg_type,
  input  logic [BYTE_W-1:0]  msg_seq,
  input  logic [BYTE_W-1:0]  frame_len,
  input  logic [TS_BITS-1:0] timestamp,
  input  logic [TS_BITS-1:0] reply_delay,
  input  logic [BYTE_W-1:0]  magic_first,
  input  logic [BYTE_W-1:0]  magic_second,
  input  logic [SEQ_W-1:0]   sequence_cur,
  input  logic [TS_BITS-1:0] poll_time,
  output resp_chk_t          chk
);

  logic [TS_BITS-1:0] round_trip;

  // Wraps modulo the timestamp range by width alone.
  assign round_trip = timestamp - poll_time;

  assign chk.fmt_ok    = (hdr_byte0 == magic_first) && (hdr_byte1 == magic_second) &&
                         (msg_type == MSG_TYPE_RESP) && (msg_seq == sequence_cur) &&
                         (frame_len >= MIN_FRAME_LEN);
  assign chk.too_short = round_trip < reply_delay;
  assign chk.ticks     = round_trip - reply_delay;

endmodule

// ----- hw/rtl/uwbtwr_scale.sv -----
// Tick-to-millimetre scaling: (ticks * scale) >> SCALE_SHIFT, saturated.
// Depends on uwbtwr_pkg for widths.
module uwbtwr_scale import uwbtwr_pkg::*; (
  input  logic [TS_BITS-1:0] ticks,
  input  logic [SCALE_W-1:0] scale,
  output logic [DIST_W-1:0]  dist_mm
);

  localparam int PROD_W = TS_BITS + SCALE_W;
  localparam int SH_W   = PROD_W - SCALE_SHIFT;

  logic [PROD_W-1:0] prod;
  logic [SH_W-1:0]   shifted;

  assign prod    = {{SCALE_W{1'b0}}, ticks} * {{TS_BITS{1'b0}}, scale};
  assign shifted = prod[PROD_W-1:SCALE_SHIFT];
  // Clamp anything above the top distance bit.
  assign dist_mm = (|shifted[SH_W-1:DIST_W]) ? {DIST_W{1'b1}} : shifted[DIST_W-1:0];

endmodule

// ----- hw/rtl/uwb_twr_initiator_ranging.sv -----
// Initiator side of single-sided two-way ranging: one result per event.
// From input transaction to result valid: input register, then check stage register,
// then result register after the scale stage. Throughput: one event per cycle unless
// out_ready stalls output; the 40x20 multiply in the scale stage sets the longest path.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes sequence, poll time
// and held distance, and loads the configuration registers with their defaults.
module uwb_twr_initiator_ranging import uwbtwr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]   cfg_data,
  // event input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_mode,
  input  logic [TS_BITS-1:0]   in_timestamp,
  input  logic [BYTE_W-1:0]    in_hdr_byte0,
  input  logic [BYTE_W-1:0]    in_hdr_byte1,
  input  logic [BYTE_W-1:0]    in_msg_type,
  input  logic [BYTE_W-1:0]    in_msg_seq,
  input  logic [BYTE_W-1:0]    in_frame_len,
  input  logic [TS_BITS-1:0]   in_reply_delay,
  // result output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [2:0]           out_send_type,
  output logic [SEQ_W-1:0]     out_send_seq,
  output logic [DIST_W-1:0]    out_distance_mm,
  output logic                 out_distance_valid
);

  // configuration
  logic [SCALE_W-1:0] scale_r;
  logic [BYTE_W-1:0]  magic_first_r;
  logic [BYTE_W-1:0]  magic_second_r;

  // ranging state
  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic [TS_BITS-1:0] poll_time_r, poll_time_nxt;
  logic [DIST_W-1:0]  dist_r;
  logic               have_r;

  // input register
  logic               s0_vld_r;
  mode_t              s0_mode_r;
  logic [TS_BITS-1:0] s0_ts_r;
  logic [BYTE_W-1:0]  s0_b0_r, s0_b1_r, s0_type_r, s0_seq_r, s0_len_r;
  logic [TS_BITS-1:0] s0_delay_r;

  // check stage register
  logic               s1_vld_r;
  status_t            s1_status_r, s1_status_nxt;
  send_t              s1_send_r, s1_send_nxt;
  logic [SEQ_W-1:0]   s1_seq_r;
  logic               s1_calc_r, s1_calc_nxt;
  logic [TS_BITS-1:0] s1_ticks_r;

  // result register
  logic               out_vld_r;
  status_t            out_status_r, out_status_nxt;
  send_t              out_send_r, out_send_nxt;
  logic [SEQ_W-1:0]   out_seq_r;
  logic [DIST_W-1:0]  out_dist_r, dist_nxt;
  logic               out_have_r, have_nxt;

  logic s2_free, s1_free, s1_move, s0_free, s0_move, in_acc;

  resp_chk_t          chk;
  logic [DIST_W-1:0]  scaled_mm;

  assign s2_free  = !out_vld_r || out_ready;
  assign s1_move  = s1_vld_r && s2_free;
  assign s1_free  = !s1_vld_r || s2_free;
  assign s0_move  = s0_vld_r && s1_free;
  assign s0_free  = !s0_vld_r || s1_free;
  assign in_ready = s0_free;
  assign in_acc   = in_valid && s0_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r        <= SCALE_RST;
      magic_first_r  <= MAGIC_FIRST_RST;
      magic_second_r <= MAGIC_SECOND_RST;
    end else if (cfg_valid) begin
      // drop writes to unmapped indexes
      case (cfg_idx_t'(cfg_index))
        CFG_SCALE:        scale_r        <= cfg_data;
        CFG_MAGIC_FIRST:  magic_first_r  <= cfg_data[BYTE_W-1:0];
        CFG_MAGIC_SECOND: magic_second_r <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_acc) begin
      s0_vld_r <= 1'b1;
    end else if (s0_move) begin
      s0_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_mode_r  <= mode_t'(in_mode);
      s0_ts_r    <= in_timestamp;
      s0_b0_r    <= in_hdr_byte0;
      s0_b1_r    <= in_hdr_byte1;
      s0_type_r  <= in_msg_type;
      s0_seq_r   <= in_msg_seq;
      s0_len_r   <= in_frame_len;
      s0_delay_r <= in_reply_delay;
    end
  end

  // ---------------- check stage ----------------
  uwbtwr_resp_chk u_chk (
    .hdr_byte0    (s0_b0_r),
    .hdr_byte1    (s0_b1_r),
    .msg_type     (s0_type_r),
    .msg_seq      (s0_seq_r),
    .frame_len    (s0_len_r),
    .timestamp    (s0_ts_r),
    .reply_delay  (s0_delay_r),
    .magic_first  (magic_first_r),
    .magic_second (magic_second_r),
    .sequence_cur (seq_r),
    .poll_time    (poll_time_r),
    .chk          (chk)
  );

  always_comb begin
    seq_nxt       = seq_r;
    poll_time_nxt = poll_time_r;
    s1_status_nxt = ST_IDLE_ACK;
    s1_send_nxt   = SEND_NONE;
    s1_calc_nxt   = 1'b0;
    unique case (s0_mode_r)
      MODE_START: begin
        seq_nxt     = seq_r + SEQ_W'(1);
        s1_send_nxt = SEND_POLL;
      end
      MODE_POLL_SENT: begin
        poll_time_nxt = s0_ts_r;
      end
      MODE_RESP: begin
        priority if (!chk.fmt_ok) begin
          s1_status_nxt = ST_BAD_FMT;
        end else if (chk.too_short) begin
          s1_status_nxt = ST_NEG_FLIGHT;
        end else begin
          // final status and frame are set once the distance is known
          s1_calc_nxt = 1'b1;
        end
      end
      MODE_TIMEOUT: begin
        s1_status_nxt = ST_TIMEOUT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      seq_r       <= '0;
      poll_time_r <= '0;
    end else begin
      if (s0_move) begin
        s1_vld_r    <= 1'b1;
        seq_r       <= seq_nxt;
        poll_time_r <= poll_time_nxt;
      end else if (s1_move) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_move) begin
      s1_status_r <= s1_status_nxt;
      s1_send_r   <= s1_send_nxt;
      s1_seq_r    <= seq_nxt;
      s1_calc_r   <= s1_calc_nxt;
      s1_ticks_r  <= chk.ticks;
    end
  end

  // ---------------- scale stage ----------------
  uwbtwr_scale u_scale (
    .ticks   (s1_ticks_r),
    .scale   (scale_r),
    .dist_mm (scaled_mm)
  );

  always_comb begin
    if (s1_calc_r) begin
      dist_nxt       = scaled_mm;
      have_nxt       = 1'b1;
      out_status_nxt = ST_OK;
      out_send_nxt   = SEND_RESULT;
    end else begin
      dist_nxt       = dist_r;
      have_nxt       = have_r;
      out_status_nxt = s1_status_r;
      out_send_nxt   = s1_send_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      dist_r    <= '0;
      have_r    <= 1'b0;
    end else begin
      if (s1_move) begin
        out_vld_r <= 1'b1;
        dist_r    <= dist_nxt;
        have_r    <= have_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_status_r <= out_status_nxt;
      out_send_r   <= out_send_nxt;
      out_seq_r    <= s1_seq_r;
      out_dist_r   <= dist_nxt;
      out_have_r   <= have_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = out_status_r;
  assign out_send_type      = out_send_r;
  assign out_send_seq       = out_seq_r;
  assign out_distance_mm    = out_dist_r;
  assign out_distance_valid = out_have_r;

  // ---------------- assertions ----------------
  a_ok_means_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_status_r == ST_OK) |-> (out_send_r == SEND_RESULT && out_have_r))
    else $error("ok status without result frame");

  a_have_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |=> have_r)
    else $error("distance valid flag cleared");

  a_dist_needs_have: assert property (@(posedge clk) disable iff (!rst_n)
    (dist_r != '0) |-> have_r)
    else $error("distance held without a successful range");

  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_move && s0_mode_r == MODE_START) |=> (seq_r == $past(seq_r) + SEQ_W'(1)))
    else $error("sequence did not advance on start");

endmodule
